// ===== rtl/core/bob_pkg.sv =====
// shared constants and types of the bob deinterlacer
`default_nettype none

package bob_pkg;

   // frame limits
   localparam int MAX_WIDTH       = 2048;
   localparam int MAX_FIELD_LINES = 1024;

   // datapath widths
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(2 * MAX_FIELD_LINES);
   localparam int PIX_W = 8;

   // register file widths
   localparam int LW_W       = 12;
   localparam int FL_W       = 11;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_LINES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERPOLATE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ODD   = 2'd3;

   // position of one input pixel in the frame
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             odd;
   } pos_type;

   // settings seen by the result logic
   typedef struct packed {
      logic [ROW_W-1:0] last_row;
      logic [COL_W-1:0] last_col;
      logic             interp;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/bob_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module bob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write, holds when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bob_pos.sv =====
// configuration registers and row / column / parity counters
`default_nettype none

module bob_pos (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [bob_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bob_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           take,
   output bob_pkg::pos_type                    pos,
   output bob_pkg::cfg_type                    cfg
);

   localparam int WC_W = bob_pkg::COL_W + 1;
   localparam int WR_W = bob_pkg::ROW_W + 1;

   logic [WC_W-1:0]           width_ff, width_in;
   logic [WR_W-1:0]           rows_ff, rows_in;
   logic                      interp_ff, interp_in;
   logic                      pass_ff, pass_in;
   logic [bob_pkg::COL_W-1:0] col_ff, col_in;
   logic [bob_pkg::ROW_W-1:0] row_ff, row_in;

   logic [bob_pkg::LW_W-1:0]  lw;
   logic [bob_pkg::FL_W-1:0]  fl;
   logic [bob_pkg::ROW_W-1:0] lines;

   logic                      wrap_c, wrap_r, end_c, end_r;
   logic [WR_W-1:0]           row_a, row_b;
   logic [WC_W-1:0]           col_b;
   logic [bob_pkg::COL_W-1:0] col_cur;
   logic [bob_pkg::ROW_W-1:0] row_cur;
   logic                      odd_cur;

   assign lw = csr_wdata[bob_pkg::LW_W-1:0];
   assign fl = csr_wdata[bob_pkg::FL_W-1:0];

   // current position, wrapping leftovers from a settings change first
   always_comb begin
      wrap_c  = {1'b0, col_ff} >= width_ff;
      col_cur = wrap_c ? '0 : col_ff;
      row_a   = {1'b0, row_ff} + WR_W'(wrap_c);
      wrap_r  = row_a >= rows_ff;
      row_cur = wrap_r ? '0 : row_a[bob_pkg::ROW_W-1:0];
      odd_cur = pass_ff ^ wrap_r;
   end

   // advance past the current pixel
   always_comb begin
      col_b = {1'b0, col_cur} + WC_W'(1);
      end_c = col_b >= width_ff;
      row_b = {1'b0, row_cur} + WR_W'(1);
      end_r = row_b >= rows_ff;
   end

   // next state of counters and registers
   always_comb begin
      width_in  = width_ff;
      rows_in   = rows_ff;
      interp_in = interp_ff;
      pass_in   = pass_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      lines     = '0;
      if (take) begin
         if (end_c) begin
            col_in = '0;
            row_in = end_r ? '0 : row_b[bob_pkg::ROW_W-1:0];
         end else begin
            col_in = col_b[bob_pkg::COL_W-1:0];
            row_in = row_cur;
         end
         pass_in = odd_cur ^ (end_c & end_r);
      end
      if (csr_write) begin
         case (csr_index)
            bob_pkg::CSR_LINE_WIDTH: begin
               if (32'(lw) > 32'(bob_pkg::MAX_WIDTH)) begin
                  width_in = WC_W'(bob_pkg::MAX_WIDTH);
               end else if (lw == '0) begin
                  width_in = WC_W'(1);
               end else begin
                  width_in = WC_W'(lw);
               end
            end
            bob_pkg::CSR_FIELD_LINES: begin
               if (32'(fl) > 32'(bob_pkg::MAX_FIELD_LINES)) begin
                  lines = bob_pkg::ROW_W'(bob_pkg::MAX_FIELD_LINES);
               end else if (fl == '0) begin
                  lines = bob_pkg::ROW_W'(1);
               end else begin
                  lines = bob_pkg::ROW_W'(fl);
               end
               rows_in = {lines, 1'b0};
            end
            bob_pkg::CSR_INTERPOLATE: interp_in = csr_wdata[0];
            bob_pkg::CSR_FIRST_ODD:   pass_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // register bank, reset loads the power-on settings
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WC_W'(640);
         rows_ff   <= WR_W'(480);
         interp_ff <= 1'b0;
         pass_ff   <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         rows_ff   <= rows_in;
         interp_ff <= interp_in;
         pass_ff   <= pass_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   assign pos.row      = row_cur;
   assign pos.col      = col_cur;
   assign pos.odd      = odd_cur;
   assign cfg.last_row = bob_pkg::ROW_W'(rows_ff - WR_W'(1));
   assign cfg.last_col = bob_pkg::COL_W'(width_ff - WC_W'(1));
   assign cfg.interp   = interp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bob_form.sv =====
// pixel stage, result forming and two-beat output buffer
`default_nettype none

module bob_form (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       take,
   input  wire logic [bob_pkg::PIX_W-1:0]  pixel,
   input  bob_pkg::pos_type                pos,
   input  bob_pkg::cfg_type                cfg,
   input  wire logic [bob_pkg::PIX_W-1:0]  rd_data,
   output logic                            busy,
   output logic                            wr_en,
   output logic [bob_pkg::COL_W-1:0]       wr_addr,
   output logic [bob_pkg::PIX_W-1:0]       wr_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [bob_pkg::ROW_W-1:0]       rsp_out_row,
   output logic [bob_pkg::COL_W-1:0]       rsp_out_col,
   output logic [bob_pkg::PIX_W-1:0]       rsp_value,
   output logic                            rsp_run_last,
   output logic                            rsp_frame_last
);

   // pixel stage
   logic                      s1_valid_ff, s1_valid_in;
   logic [bob_pkg::PIX_W-1:0] s1_pixel_ff;
   bob_pkg::pos_type          s1_pos_ff;
   logic                      s1_fwd_ff;
   logic [bob_pkg::PIX_W-1:0] s1_fwd_data_ff;

   // output pair
   logic                      ob_valid_ff, ob_valid_in;
   logic                      ob_second_ff, ob_second_in;
   logic [bob_pkg::ROW_W-1:0] ob_row0_ff, ob_row1_ff;
   logic [bob_pkg::PIX_W-1:0] ob_val0_ff, ob_val1_ff;
   logic [bob_pkg::COL_W-1:0] ob_col_ff;
   logic                      ob_flast_ff;

   logic [bob_pkg::PIX_W-1:0] stored, p;
   logic [bob_pkg::PIX_W:0]   sum;
   logic [bob_pkg::PIX_W-1:0] avg;
   logic [bob_pkg::ROW_W-1:0] r, row0, row1;
   logic [bob_pkg::PIX_W-1:0] val0, val1;
   logic                      emit, keep, flast;
   logic                      rsp_take, ob_free, s1_go, load;

   // line store data, bypassed when the previous beat wrote the same column
   assign stored = s1_fwd_ff ? s1_fwd_data_ff : rd_data;
   assign p      = s1_pixel_ff;
   assign r      = s1_pos_ff.row;
   assign sum    = {1'b0, stored} + {1'b0, p};
   assign avg    = sum[bob_pkg::PIX_W:1];

   // result rows and values for the pixel in the stage
   always_comb begin
      row0 = r - bob_pkg::ROW_W'(1);
      row1 = r;
      val0 = stored;
      val1 = stored;
      emit = 1'b0;
      if (s1_pos_ff.odd) begin
         emit = r[0];
         val0 = (cfg.interp && r > bob_pkg::ROW_W'(1)) ? avg : p;
         val1 = p;
      end else if (!r[0]) begin
         emit = r >= bob_pkg::ROW_W'(2);
         row0 = r - bob_pkg::ROW_W'(2);
         row1 = r - bob_pkg::ROW_W'(1);
         val1 = cfg.interp ? avg : stored;
      end else begin
         emit = r == cfg.last_row;
      end
      keep  = r[0] == s1_pos_ff.odd;
      flast = (row1 == cfg.last_row) && (s1_pos_ff.col == cfg.last_col);
   end

   // handshake between stage, buffer and result channel
   assign rsp_take = ob_valid_ff && !rsp_stall;
   assign ob_free  = !ob_valid_ff || (rsp_take && ob_second_ff);
   assign s1_go    = s1_valid_ff && (!emit || ob_free);
   assign load     = s1_go && emit;
   assign busy     = s1_valid_ff && !s1_go;

   // line store write of kept rows
   assign wr_en   = s1_go && keep;
   assign wr_addr = s1_pos_ff.col;
   assign wr_data = p;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      ob_valid_in  = ob_valid_ff;
      ob_second_in = ob_second_ff;
      if (load) begin
         ob_valid_in  = 1'b1;
         ob_second_in = 1'b0;
      end else if (rsp_take) begin
         if (ob_second_ff) begin
            ob_valid_in = 1'b0;
         end else begin
            ob_second_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         ob_valid_ff  <= 1'b0;
         ob_second_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         ob_valid_ff  <= ob_valid_in;
         ob_second_ff <= ob_second_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (take) begin
         s1_pixel_ff    <= pixel;
         s1_pos_ff      <= pos;
         s1_fwd_ff      <= wr_en && (wr_addr == pos.col);
         s1_fwd_data_ff <= wr_data;
      end
   end

   // buffer payload
   always_ff @(posedge clock) begin
      if (load) begin
         ob_row0_ff  <= row0;
         ob_row1_ff  <= row1;
         ob_val0_ff  <= val0;
         ob_val1_ff  <= val1;
         ob_col_ff   <= s1_pos_ff.col;
         ob_flast_ff <= flast;
      end
   end

   assign rsp_valid      = ob_valid_ff;
   assign rsp_out_row    = ob_second_ff ? ob_row1_ff : ob_row0_ff;
   assign rsp_out_col    = ob_col_ff;
   assign rsp_value      = ob_second_ff ? ob_val1_ff : ob_val0_ff;
   assign rsp_run_last   = ob_second_ff;
   assign rsp_frame_last = ob_second_ff && ob_flast_ff;

   // a taken first beat is followed by the second beat of its pair
   a_pair_completes: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !ob_second_ff |=> rsp_valid && rsp_run_last)
      else $error("second beat of a pair missing");

   // a new pair always starts on its first beat
   a_pair_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid && !rsp_run_last)
      else $error("pair loaded without first beat");

   // no pair is loaded over one whose first beat is still pending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ob_valid_ff && !ob_second_ff |-> !load)
      else $error("output pair overwritten");

   // an accepted pixel occupies the stage in the next cycle
   a_stage_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> s1_valid_ff)
      else $error("accepted pixel lost");

endmodule

`default_nettype wire

// ===== rtl/core/bob_deinterlacer_core.sv =====
// top level of the bob deinterlacer
`default_nettype none

// Bob deinterlacer for 8-bit gray frames fed in raster order, once per field.
// A pixel is taken in every cycle while the result side keeps up. Pixels that
// cause no result (dropped rows but the last row of an even pass, and the
// first kept row of an even pass) leave at one pixel per cycle; any other
// pixel yields a pair of result beats, upper row first, so such rows are
// paced by the single result channel moving one beat per cycle while
// rsp_stall is low. The first beat of a pair passes the pixel stage, fed by
// the registered line store read (one ram of MAX_WIDTH entries, one write and
// one read port), and then the output register. Settings are to be written
// only while the block is idle, which the block does not enforce; a write of
// first_odd reloads the pass parity; the row and column counters hold.

module bob_deinterlacer_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // pixel input
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [bob_pkg::PIX_W-1:0]      req_pixel,
   // result output
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [bob_pkg::ROW_W-1:0]           rsp_out_row,
   output logic [bob_pkg::COL_W-1:0]           rsp_out_col,
   output logic [bob_pkg::PIX_W-1:0]           rsp_value,
   output logic                                rsp_run_last,
   output logic                                rsp_frame_last,
   // settings
   input  wire logic                           csr_write,
   input  wire logic [bob_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bob_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic                      take, busy;
   bob_pkg::pos_type          pos;
   bob_pkg::cfg_type          cfg;
   logic                      wr_en;
   logic [bob_pkg::COL_W-1:0] wr_addr;
   logic [bob_pkg::PIX_W-1:0] wr_data, rd_data;

   // input beat accepted
   assign take      = req_valid && !busy;
   assign req_stall = busy;

   // settings and counters
   bob_pos u_pos (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .pos       (pos),
      .cfg       (cfg)
   );

   // one-line store
   bob_ram #(
      .WIDTH (bob_pkg::PIX_W),
      .DEPTH (bob_pkg::MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (take),
      .rd_addr (pos.col),
      .rd_data (rd_data)
   );

   // results
   bob_form u_form (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .pixel          (req_pixel),
      .pos            (pos),
      .cfg            (cfg),
      .rd_data        (rd_data),
      .busy           (busy),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_value      (rsp_value),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire
